/* design/assert_macros.svh */
// Assertion macros used by the encoder design.
// Each use expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on a given clock, disabled while the given active-low reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the house clock and reset.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK_RST(label, i_clk, i_rst_n, prop, msg)

`endif

/* design/hre_pkg.sv */
// ----------------------------------------------------------------------------
// hre_pkg
// Constants, control word types and microcode table of the hex record encoder.
// ----------------------------------------------------------------------------
package hre_pkg;

    // Record geometry and capacity.
    localparam int WORDS_PER_RECORD = 8;
    localparam int MAX_WORDS        = 1024;

    // Counter widths: the word counter can run a full record past capacity on an end item.
    localparam int WC_W   = $clog2(MAX_WORDS + WORDS_PER_RECORD + 1);
    localparam int SLOT_W = (WORDS_PER_RECORD > 1) ? $clog2(WORDS_PER_RECORD) : 1;

    // Byte count field of every data record.
    localparam logic [7:0] COUNT_BYTE = 8'((2 * WORDS_PER_RECORD) % 256);

    // ASCII characters used in the text.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Program layout.
    localparam int NUM_STEPS = 29;
    localparam int PC_W      = $clog2(NUM_STEPS);

    localparam logic [PC_W-1:0] STEP_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_HDR       = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_DATA      = PC_W'(10);
    localparam logic [PC_W-1:0] STEP_CHECK     = PC_W'(14);
    localparam logic [PC_W-1:0] STEP_END_FIRST = PC_W'(17);
    localparam logic [PC_W-1:0] STEP_END_LAST  = PC_W'(28);

    // Character source of a step.
    typedef enum logic [0:0] {
        SRC_LIT,
        SRC_HEX
    } t_char_src;

    // Byte feeding the hex digit and the checksum adder.
    typedef enum logic [2:0] {
        BYTE_COUNT,
        BYTE_ADDR_HI,
        BYTE_ADDR_LO,
        BYTE_DATA_LO,
        BYTE_DATA_HI,
        BYTE_CHECK
    } t_byte_sel;

    // Running sum operation.
    typedef enum logic [1:0] {
        SUM_NONE,
        SUM_LOAD,
        SUM_ADD
    } t_sum_op;

    // Sequencing of a step.
    typedef enum logic [1:0] {
        JMP_NEXT,      // go to the following step
        JMP_REC_END,   // record closes: next; else padding loops to target, words finish
        JMP_LINE_END,  // end item continues with the end record, words finish
        JMP_DONE       // back to the idle step
    } t_jump;

    // One control word of the microcode.
    typedef struct packed {
        logic              emit;
        t_char_src         src;
        logic              nib_hi;
        logic [7:0]        lit;
        t_byte_sel         bsel;
        t_sum_op           sop;
        logic              adv_word;
        logic              clr;
        t_jump             jmp;
        logic [PC_W-1:0]   target;
    } t_ctrl;

    // Builds a literal character step.
    function automatic t_ctrl mk_lit(input logic [7:0] ch, input t_jump jmp,
                                     input logic clr);
        t_ctrl c;
        c          = '0;
        c.emit     = 1'b1;
        c.src      = SRC_LIT;
        c.lit      = ch;
        c.bsel     = BYTE_COUNT;
        c.sop      = SUM_NONE;
        c.clr      = clr;
        c.jmp      = jmp;
        c.target   = STEP_IDLE;
        return c;
    endfunction

    // Builds a hex digit step.
    function automatic t_ctrl mk_hex(input t_byte_sel bsel, input logic nib_hi,
                                     input t_sum_op sop, input logic adv_word,
                                     input t_jump jmp);
        t_ctrl c;
        c          = '0;
        c.emit     = 1'b1;
        c.src      = SRC_HEX;
        c.nib_hi   = nib_hi;
        c.bsel     = bsel;
        c.sop      = sop;
        c.adv_word = adv_word;
        c.jmp      = jmp;
        c.target   = STEP_DATA;
        return c;
    endfunction

    // Microcode table: header, data word, checksum and newline, end record.
    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c     = '0;
        c.jmp = JMP_DONE;
        case (pc)
            PC_W'(1):  c = mk_lit(CH_COLON, JMP_NEXT, 1'b0);
            PC_W'(2):  c = mk_hex(BYTE_COUNT,   1'b1, SUM_LOAD, 1'b0, JMP_NEXT);
            PC_W'(3):  c = mk_hex(BYTE_COUNT,   1'b0, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(4):  c = mk_hex(BYTE_ADDR_HI, 1'b1, SUM_ADD,  1'b0, JMP_NEXT);
            PC_W'(5):  c = mk_hex(BYTE_ADDR_HI, 1'b0, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(6):  c = mk_hex(BYTE_ADDR_LO, 1'b1, SUM_ADD,  1'b0, JMP_NEXT);
            PC_W'(7):  c = mk_hex(BYTE_ADDR_LO, 1'b0, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(8):  c = mk_lit(CH_ZERO, JMP_NEXT, 1'b0);
            PC_W'(9):  c = mk_lit(CH_ZERO, JMP_NEXT, 1'b0);
            PC_W'(10): c = mk_hex(BYTE_DATA_LO, 1'b1, SUM_ADD,  1'b0, JMP_NEXT);
            PC_W'(11): c = mk_hex(BYTE_DATA_LO, 1'b0, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(12): c = mk_hex(BYTE_DATA_HI, 1'b1, SUM_ADD,  1'b0, JMP_NEXT);
            PC_W'(13): c = mk_hex(BYTE_DATA_HI, 1'b0, SUM_NONE, 1'b1, JMP_REC_END);
            PC_W'(14): c = mk_hex(BYTE_CHECK,   1'b1, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(15): c = mk_hex(BYTE_CHECK,   1'b0, SUM_NONE, 1'b0, JMP_NEXT);
            PC_W'(16): c = mk_lit(CH_NL,      JMP_LINE_END, 1'b0);
            PC_W'(17): c = mk_lit(CH_COLON,   JMP_NEXT, 1'b0);
            PC_W'(18): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(19): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(20): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(21): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(22): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(23): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(24): c = mk_lit(CH_ZERO,    JMP_NEXT, 1'b0);
            PC_W'(25): c = mk_lit(CH_ONE,     JMP_NEXT, 1'b0);
            PC_W'(26): c = mk_lit(CH_UPPER_F, JMP_NEXT, 1'b0);
            PC_W'(27): c = mk_lit(CH_UPPER_F, JMP_NEXT, 1'b0);
            PC_W'(28): c = mk_lit(CH_NL,      JMP_DONE, 1'b1);
            default:   c.emit = 1'b0;
        endcase
        return c;
    endfunction

    // Uppercase hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_ZERO + {4'b0, n};
        end else begin
            r = CH_UPPER_A + {4'b0, n} - 8'd10;
        end
        return r;
    endfunction

endpackage

/* design/hre_in_if.sv */
// ----------------------------------------------------------------------------
// hre_in_if
// Input channel of the hex record encoder: one program word or end marker.
// ----------------------------------------------------------------------------
interface hre_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] word;

    modport source (output valid, output kind, output word, input ready);
    modport sink   (input valid, input kind, input word, output ready);
endinterface

/* design/hre_out_if.sv */
// ----------------------------------------------------------------------------
// hre_out_if
// Output channel of the hex record encoder: one ASCII character per word.
// ----------------------------------------------------------------------------
interface hre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_char;
    logic       last;
    logic       refused;

    modport source (output valid, output ascii_char, output last, output refused,
                    input ready);
    modport sink   (input valid, input ascii_char, input last, input refused,
                    output ready);
endinterface

/* design/hex_record_encoder.sv */
// ----------------------------------------------------------------------------
// hex_record_encoder
// Microcoded encoder of 16-bit program words into Intel HEX text.
// ----------------------------------------------------------------------------
// Usage: i_in carries one word per item: kind 0 is a program word, kind 1
// ends the program. o_out carries the text one character per word, with
// last set on the final character that an input item causes.
// A sequencer steps through a 29-step control table, one character per
// cycle while the output is not stalled; the input is taken only while it
// sits at its idle step and the output register is free. A word in the
// middle of a record gives 4 characters, a record's first word 13, a
// record's last word 3 more for checksum and newline. On accept the
// sequencer moves to its first step, which registers its character.
// An end item pads the open record (or writes a full zero record), then
// writes ":00000001FF" and a newline, and restarts at address 0.
// A word beyond capacity gives one refused word with last set, state kept.
// Reset clears the address, record slot and sum, and empties the output.
// When the receiver stalls, the held character stays and the sequencer
// waits on the same step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_record_encoder
    import hre_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    hre_in_if.sink        i_in,
    hre_out_if.source     o_out
);

    // Control state.
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [WC_W-1:0]   r_wc, n_wc;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [7:0]        r_sum, n_sum;
    logic              r_end, n_end;
    logic              r_out_valid, n_out_valid;

    // Payload registers.
    logic [15:0]       r_data;
    logic [7:0]        r_out_char;
    logic              r_out_last;
    logic              r_out_refused;

    t_ctrl             cw;
    logic              idle, out_free, in_acc, full, refuse, closing, step_go;
    logic [31:0]       addr_wide;
    logic [15:0]       addr;
    logic [7:0]        sel_byte;
    logic [3:0]        nibble;
    logic [7:0]        step_char;

    // Decode the current step and the handshakes.
    always_comb begin
        cw       = ctrl_rom(r_pc);
        idle     = (r_pc == STEP_IDLE);
        out_free = !r_out_valid || o_out.ready;
        in_acc   = i_in.valid && i_in.ready;
        full     = (r_wc == WC_W'(MAX_WORDS));
        refuse   = in_acc && !i_in.kind && full;
        closing  = (r_slot == SLOT_W'(WORDS_PER_RECORD - 1));
        step_go  = !idle && (!cw.emit || out_free);
    end

    assign i_in.ready = idle && out_free;

    // Byte address of the next word, wrapped to 16 bits.
    assign addr_wide = 32'(r_wc) << 1;
    assign addr      = addr_wide[15:0];

    // Byte and character selection.
    always_comb begin
        unique case (cw.bsel)
            BYTE_COUNT:   sel_byte = COUNT_BYTE;
            BYTE_ADDR_HI: sel_byte = addr[15:8];
            BYTE_ADDR_LO: sel_byte = addr[7:0];
            BYTE_DATA_LO: sel_byte = r_data[7:0];
            BYTE_DATA_HI: sel_byte = r_data[15:8];
            BYTE_CHECK:   sel_byte = 8'(8'd0 - r_sum);
            default:      sel_byte = 8'd0;
        endcase
        nibble = cw.nib_hi ? sel_byte[7:4] : sel_byte[3:0];
        unique case (cw.src)
            SRC_LIT: step_char = cw.lit;
            SRC_HEX: step_char = hex_char(nibble);
            default: step_char = cw.lit;
        endcase
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_pc        = r_pc;
        n_wc        = r_wc;
        n_slot      = r_slot;
        n_sum       = r_sum;
        n_end       = r_end;
        n_out_valid = r_out_valid;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (idle) begin
            // Dispatch: a refused word answers at once, others run the program.
            if (in_acc) begin
                n_end = i_in.kind;
                if (refuse) begin
                    n_out_valid = 1'b1;
                end else if (r_slot != '0) begin
                    n_pc = STEP_DATA;
                end else begin
                    n_pc = STEP_HDR;
                end
            end
        end else if (step_go) begin
            if (cw.emit) begin
                n_out_valid = 1'b1;
            end

            unique case (cw.sop)
                SUM_LOAD: n_sum = sel_byte;
                SUM_ADD:  n_sum = r_sum + sel_byte;
                default:  n_sum = r_sum;
            endcase

            if (cw.adv_word) begin
                n_wc   = r_wc + WC_W'(1);
                n_slot = closing ? '0 : r_slot + SLOT_W'(1);
            end

            unique case (cw.jmp)
                JMP_NEXT:     n_pc = r_pc + PC_W'(1);
                JMP_REC_END:  n_pc = closing ? r_pc + PC_W'(1)
                                             : (r_end ? cw.target : STEP_IDLE);
                JMP_LINE_END: n_pc = r_end ? r_pc + PC_W'(1) : STEP_IDLE;
                JMP_DONE:     n_pc = STEP_IDLE;
                default:      n_pc = STEP_IDLE;
            endcase

            // The end record restarts the program at address 0.
            if (cw.clr) begin
                n_wc   = '0;
                n_slot = '0;
                n_sum  = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_IDLE;
            r_wc        <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_wc        <= n_wc;
            r_slot      <= n_slot;
            r_sum       <= n_sum;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: input word and output character.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_data <= i_in.kind ? 16'd0 : i_in.word;
        end
        if (refuse) begin
            r_out_char    <= 8'd0;
            r_out_last    <= 1'b1;
            r_out_refused <= 1'b1;
        end else if (step_go && cw.emit) begin
            r_out_char    <= step_char;
            r_out_last    <= (n_pc == STEP_IDLE);
            r_out_refused <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_out_char;
    assign o_out.last       = r_out_last;
    assign o_out.refused    = r_out_refused;

    // A refused word is always a single word that closes its item.
    `ASSERT_STD(a_refused_last, (o_out.valid && o_out.refused) |-> o_out.last,
        "refused word without last")

    // A stalled output holds the sequencer on its step.
    `ASSERT_STD(a_stall_holds_pc, (!idle && cw.emit && r_out_valid && !o_out.ready)
        |=> $stable(r_pc), "sequencer advanced under stall")

    // Between items the word counter never passes capacity.
    `ASSERT_STD(a_capacity, idle |-> (r_wc <= WC_W'(MAX_WORDS)),
        "word counter beyond capacity at idle")

    // The end record leaves the encoder at address 0 with no record open.
    `ASSERT_STD(a_end_clears, (r_pc == STEP_END_LAST && step_go)
        |=> (r_wc == '0 && r_slot == '0 && idle), "end record did not restart")

endmodule
